@@ rtl/core/soft_viterbi_k5_depunctured_decoder_macros.svh @@
// assertion macros for the soft viterbi decoder
`ifndef SOFT_VITERBI_K5_DEPUNCTURED_DECODER_MACROS_SVH
`define SOFT_VITERBI_K5_DEPUNCTURED_DECODER_MACROS_SVH

// same-cycle implication under the block reset
`define SVD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// next-cycle implication under the block reset
`define SVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

@@ rtl/core/svd_pkg.sv @@
// shared constants and types of the soft viterbi decoder
`default_nettype none
package svd_pkg;
    localparam int MAX_STEPS_DEF  = 256;
    localparam int NUM_STATES     = 16;
    localparam int PATTERN_MAX    = 64;

    localparam logic [15:0] ERASURE    = 16'h7FFF;
    localparam logic [16:0] BM_SUM     = 17'h1FFFE;
    localparam logic [31:0] BIG_METRIC = 32'h3FFFFFFF;
    localparam logic [31:0] ERR_COST   = 32'hFFFFFFFF;

    // expected code bits per butterfly, bit i for butterfly i
    localparam logic [7:0] EXP_A_MASK = 8'b1111_0000;
    localparam logic [7:0] EXP_B_MASK = 8'b0110_0110;

    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_DEPUNCT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PATTERN = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PERIOD  = 2'd2;

    typedef struct packed {
        logic [31:0] metric;
        logic        decision;
    } acs_res_t;
endpackage
`default_nettype wire

@@ rtl/core/svd_acs.sv @@
// one add-compare-select for one trellis state, shared over all states
`default_nettype none
module svd_acs (
    input  wire logic [15:0]        sym_a,
    input  wire logic [15:0]        sym_b,
    input  wire logic [31:0]        metric_lo,
    input  wire logic [31:0]        metric_hi,
    input  wire logic [2:0]         bfly,
    input  wire logic               odd,
    output svd_pkg::acs_res_t       res
);
    import svd_pkg::*;

    logic [16:0] bm0;
    logic [16:0] bm1;
    logic [15:0] da;
    logic [15:0] db;
    logic [31:0] ma;
    logic [31:0] mb;

    // distance to 0xffff is the complement
    assign da  = EXP_A_MASK[bfly] ? ~sym_a : sym_a;
    assign db  = EXP_B_MASK[bfly] ? ~sym_b : sym_b;
    assign bm0 = {1'b0, da} + {1'b0, db};
    assign bm1 = BM_SUM - bm0;

    assign ma = metric_lo + 32'(odd ? bm1 : bm0);
    assign mb = metric_hi + 32'(odd ? bm0 : bm1);

    assign res.decision = (ma >= mb);
    assign res.metric   = (ma >= mb) ? mb : ma;
endmodule
`default_nettype wire

@@ rtl/core/soft_viterbi_k5_depunctured_decoder.sv @@
// Soft-decision Viterbi decoder, K=5 rate 1/2, with optional depuncturing.
// One symbol beat is taken at a time; s_tready is high only while the block idles.
// A symbol that completes a pair keeps s_tready low through feed, one single-state
// add-compare-select pass per state (16 states) through one shared unit, commit and check;
// an unpaired symbol through feed and check. Each inserted erasure adds a feed pass, plus
// the passes and a commit when it completes a pair. The last symbol adds the minimum
// search and cost (after a final pair with an erasure, if a symbol is left), a history read
// and a bit step per traceback step, and a read, load and ready wait per result beat. No clearing pass is run.
`default_nettype none
module soft_viterbi_k5_depunctured_decoder #(
    parameter int MAX_STEPS = svd_pkg::MAX_STEPS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [svd_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [63:0]               cfg_wdata,
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    input  wire logic [15:0]               s_tdata,   // soft_symbol
    input  wire logic                      s_tlast,   // last_symbol
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    output      logic [47:0]               m_tdata,   // decoded_byte, byte_number, path_cost
    output      logic                      m_tlast,   // last_result
    output      logic                      m_tuser    // too_long
);
    import svd_pkg::*;

    localparam int SW        = $clog2(MAX_STEPS + 1);
    localparam int AW        = $clog2(MAX_STEPS);
    localparam int BW        = $clog2(MAX_STEPS + 5);
    localparam int OUT_BYTES = (MAX_STEPS + 11) / 8;
    localparam int OW        = $clog2(OUT_BYTES);
    localparam int KW        = $clog2(OUT_BYTES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FEED, S_ACS, S_COMMIT, S_CHECK, S_MIN, S_COST,
        S_TB_RD, S_TB_BIT, S_OUT_RD, S_OUT_LOAD, S_OUT_WAIT, S_ERR
    } state_t;

    state_t         state_reg, state_next;
    logic           en_reg, en_next;
    logic [63:0]    pat_reg, pat_next;
    logic [6:0]     per_reg, per_next;
    logic [15:0]    sym_reg, sym_next;
    logic           last_reg, last_next;
    logic [15:0]    held_reg, held_next;
    logic           pend_reg, pend_next;
    logic [5:0]     ppos_reg, ppos_next;
    logic [6:0]     tries_reg, tries_next;
    logic [SW-1:0]  steps_reg, steps_next;
    logic [9:0]     ecnt_reg, ecnt_next;
    logic           ovf_reg, ovf_next;
    logic           ret_reg, ret_next;
    logic [15:0]    sa_reg, sa_next;
    logic [15:0]    sb_reg, sb_next;
    logic [31:0]    pm_reg [NUM_STATES];
    logic [31:0]    pm_next [NUM_STATES];
    logic [31:0]    nm_reg [NUM_STATES];
    logic [31:0]    nm_next [NUM_STATES];
    logic [3:0]     cnt_reg, cnt_next;
    logic [15:0]    dec_reg, dec_next;
    logic [31:0]    min_reg, min_next;
    logic [24:0]    corr_reg, corr_next;
    logic [31:0]    cost_reg, cost_next;
    logic [SW-1:0]  tpos_reg, tpos_next;
    logic [BW-1:0]  bpos_reg, bpos_next;
    logic [7:0]     st_reg, st_next;
    logic [7:0]     acc_reg, acc_next;
    logic [KW-1:0]  nbytes_reg, nbytes_next;
    logic [OW-1:0]  k_reg, k_next;
    logic           mv_reg, mv_next;
    logic [47:0]    md_reg, md_next;
    logic           ml_reg, ml_next;
    logic           mu_reg, mu_next;

    // memories
    logic [15:0]    hist_mem [MAX_STEPS];
    logic [15:0]    hist_rdata;
    logic           hist_we;
    logic [AW-1:0]  hist_raddr;
    logic [7:0]     ob_mem [OUT_BYTES];
    logic [7:0]     ob_rdata;
    logic           ob_we;
    logic [OW-1:0]  ob_waddr;
    logic [7:0]     ob_wdata;

    acs_res_t       acs_res;

    // comb helpers
    logic [6:0]     p_eff;
    logic [6:0]     pos1;
    logic [5:0]     adv;
    logic           ins;
    logic [15:0]    s_cur;
    logic           full;
    logic [BW-1:0]  bpos_init;
    logic [BW:0]    nb_sum;
    logic           tb_bit;
    logic [7:0]     acc_new;
    logic           fin;
    logic           do_start;

    svd_acs u_acs (
        .sym_a     (sa_reg),
        .sym_b     (sb_reg),
        .metric_lo (pm_reg[0]),
        .metric_hi (pm_reg[NUM_STATES/2]),
        .bfly      (cnt_reg[3:1]),
        .odd       (cnt_reg[0]),
        .res       (acs_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    always_comb begin
        if (per_reg == 7'd0) begin
            p_eff = 7'd1;
        end else if (per_reg > 7'(PATTERN_MAX)) begin
            p_eff = 7'(PATTERN_MAX);
        end else begin
            p_eff = per_reg;
        end
    end

    assign pos1      = {1'b0, ppos_reg} + 7'd1;
    assign adv       = (pos1 >= p_eff) ? 6'd0 : pos1[5:0];
    assign ins       = en_reg && (7'(tries_reg + 7'd1) < p_eff) && !pat_reg[ppos_reg];
    assign s_cur     = ins ? ERASURE : sym_reg;
    assign full      = (steps_reg >= SW'(MAX_STEPS));
    assign bpos_init = BW'(steps_reg) + BW'(4);
    assign nb_sum    = {1'b0, bpos_init} + (BW+1)'(7);
    assign tb_bit    = hist_rdata[st_reg[7:4]];
    assign acc_new   = acc_reg | (8'(tb_bit) << (~bpos_reg[2:0]));
    assign fin       = ((KW'(k_reg) + KW'(1)) == nbytes_reg);
    assign hist_raddr = AW'(tpos_reg - SW'(1));

    always_comb begin
        state_next  = state_reg;
        en_next     = en_reg;
        pat_next    = pat_reg;
        per_next    = per_reg;
        sym_next    = sym_reg;
        last_next   = last_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        ppos_next   = ppos_reg;
        tries_next  = tries_reg;
        steps_next  = steps_reg;
        ecnt_next   = ecnt_reg;
        ovf_next    = ovf_reg;
        ret_next    = ret_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        pm_next     = pm_reg;
        nm_next     = nm_reg;
        cnt_next    = cnt_reg;
        dec_next    = dec_reg;
        min_next    = min_reg;
        corr_next   = corr_reg;
        cost_next   = cost_reg;
        tpos_next   = tpos_reg;
        bpos_next   = bpos_reg;
        st_next     = st_reg;
        acc_next    = acc_reg;
        nbytes_next = nbytes_reg;
        k_next      = k_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        ml_next     = ml_reg;
        mu_next     = mu_reg;
        hist_we     = 1'b0;
        ob_we       = 1'b0;
        ob_waddr    = k_reg;
        ob_wdata    = 8'd0;
        do_start    = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEPUNCT: en_next  = cfg_wdata[0];
                CFG_PATTERN: pat_next = cfg_wdata;
                CFG_PERIOD:  per_next = cfg_wdata[6:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    sym_next   = s_tdata;
                    last_next  = s_tlast;
                    tries_next = 7'd0;
                    state_next = S_FEED;
                end
            end
            S_FEED: begin
                if (ins) begin
                    tries_next = tries_reg + 7'd1;
                    if (ecnt_reg != 10'd1023) begin
                        ecnt_next = ecnt_reg + 10'd1;
                    end
                    ppos_next = adv;
                    ret_next  = 1'b0;
                end else begin
                    if (en_reg) begin
                        ppos_next = adv;
                    end
                    ret_next = 1'b1;
                end
                if (pend_reg) begin
                    pend_next = 1'b0;
                    sa_next   = held_reg;
                    sb_next   = s_cur;
                    if (full) begin
                        ovf_next   = 1'b1;
                        state_next = ins ? S_FEED : S_CHECK;
                    end else begin
                        cnt_next   = 4'd0;
                        state_next = S_ACS;
                    end
                end else begin
                    held_next  = s_cur;
                    pend_next  = 1'b1;
                    state_next = ins ? S_FEED : S_CHECK;
                end
            end
            S_ACS: begin
                // new metrics and decisions shift in from the top
                for (int j = 0; j < NUM_STATES - 1; j++) begin
                    nm_next[j] = nm_reg[j+1];
                end
                nm_next[NUM_STATES-1] = acs_res.metric;
                dec_next = {acs_res.decision, dec_reg[15:1]};
                if (cnt_reg[0]) begin
                    for (int j = 0; j < NUM_STATES/2 - 1; j++) begin
                        pm_next[j]                = pm_reg[j+1];
                        pm_next[j + NUM_STATES/2] = pm_reg[j + NUM_STATES/2 + 1];
                    end
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                pm_next    = nm_reg;
                hist_we    = 1'b1;
                steps_next = steps_reg + SW'(1);
                state_next = ret_reg ? S_CHECK : S_FEED;
            end
            S_CHECK: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (pend_reg) begin
                    // odd symbol count: pair with an erasure
                    if (ecnt_reg != 10'd1023) begin
                        ecnt_next = ecnt_reg + 10'd1;
                    end
                    pend_next = 1'b0;
                    sa_next   = held_reg;
                    sb_next   = ERASURE;
                    ret_next  = 1'b1;
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cnt_next   = 4'd0;
                        state_next = S_ACS;
                    end
                end else if (ovf_reg) begin
                    md_next    = {2'b00, ERR_COST, 6'd0, 8'd0};
                    ml_next    = 1'b1;
                    mu_next    = 1'b1;
                    mv_next    = 1'b1;
                    state_next = S_ERR;
                end else begin
                    corr_next  = 25'(ecnt_reg) * 25'(ERASURE);
                    min_next   = pm_reg[0];
                    cnt_next   = 4'd0;
                    state_next = S_MIN;
                end
            end
            S_MIN: begin
                for (int j = 0; j < NUM_STATES - 1; j++) begin
                    pm_next[j] = pm_reg[j+1];
                end
                pm_next[NUM_STATES-1] = pm_reg[0];
                if (pm_reg[1] < min_reg) begin
                    min_next = pm_reg[1];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd14) begin
                    state_next = S_COST;
                end
            end
            S_COST: begin
                cost_next   = (min_reg > 32'(corr_reg)) ? (min_reg - 32'(corr_reg)) : 32'd0;
                tpos_next   = steps_reg;
                bpos_next   = bpos_init;
                st_next     = 8'd0;
                acc_next    = 8'd0;
                nbytes_next = KW'(nb_sum >> 3);
                k_next      = '0;
                if (steps_reg == '0) begin
                    ob_we      = 1'b1;
                    ob_waddr   = '0;
                    ob_wdata   = 8'd0;
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_TB_RD;
                end
            end
            S_TB_RD: begin
                tpos_next  = tpos_reg - SW'(1);
                bpos_next  = bpos_reg - BW'(1);
                state_next = S_TB_BIT;
            end
            S_TB_BIT: begin
                st_next = {tb_bit, st_reg[7:1]};
                if ((bpos_reg[2:0] == 3'd0) || (tpos_reg == '0)) begin
                    ob_we    = 1'b1;
                    ob_waddr = OW'(bpos_reg >> 3);
                    ob_wdata = acc_new;
                    acc_next = 8'd0;
                end else begin
                    acc_next = acc_new;
                end
                state_next = (tpos_reg == '0) ? S_OUT_RD : S_TB_RD;
            end
            S_OUT_RD: begin
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                md_next    = {2'b00, (fin ? cost_reg : 32'd0), 6'(k_reg), ob_rdata};
                ml_next    = fin;
                mu_next    = 1'b0;
                mv_next    = 1'b1;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_tready) begin
                    mv_next = 1'b0;
                    if (ml_reg) begin
                        do_start   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + OW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_ERR: begin
                if (m_tready) begin
                    mv_next    = 1'b0;
                    do_start   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_start) begin
            for (int j = 0; j < NUM_STATES; j++) begin
                pm_next[j] = (j == 0) ? 32'd0 : BIG_METRIC;
            end
            held_next  = 16'd0;
            pend_next  = 1'b0;
            ppos_next  = 6'd0;
            steps_next = '0;
            ecnt_next  = 10'd0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            en_reg    <= 1'b0;
            pat_reg   <= '1;
            per_reg   <= 7'd1;
            held_reg  <= 16'd0;
            pend_reg  <= 1'b0;
            ppos_reg  <= 6'd0;
            steps_reg <= '0;
            ecnt_reg  <= 10'd0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            for (int j = 0; j < NUM_STATES; j++) begin
                pm_reg[j] <= (j == 0) ? 32'd0 : BIG_METRIC;
            end
        end else begin
            state_reg <= state_next;
            en_reg    <= en_next;
            pat_reg   <= pat_next;
            per_reg   <= per_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            ppos_reg  <= ppos_next;
            steps_reg <= steps_next;
            ecnt_reg  <= ecnt_next;
            ovf_reg   <= ovf_next;
            mv_reg    <= mv_next;
            pm_reg    <= pm_next;
        end
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        tries_reg  <= tries_next;
        ret_reg    <= ret_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        nm_reg     <= nm_next;
        cnt_reg    <= cnt_next;
        dec_reg    <= dec_next;
        min_reg    <= min_next;
        corr_reg   <= corr_next;
        cost_reg   <= cost_next;
        tpos_reg   <= tpos_next;
        bpos_reg   <= bpos_next;
        st_reg     <= st_next;
        acc_reg    <= acc_next;
        nbytes_reg <= nbytes_next;
        k_reg      <= k_next;
        md_reg     <= md_next;
        ml_reg     <= ml_next;
        mu_reg     <= mu_next;
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[steps_reg[AW-1:0]] <= dec_reg;
        end
        hist_rdata <= hist_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ob_we) begin
            ob_mem[ob_waddr] <= ob_wdata;
        end
        ob_rdata <= ob_mem[k_reg];
    end

`include "soft_viterbi_k5_depunctured_decoder_macros.svh"

    `SVD_ASSERT_SAME(a_no_overlap, s_tready, !m_tvalid)
    `SVD_ASSERT_SAME(a_err_is_last, m_tvalid && m_tuser, m_tlast && (m_tdata[13:0] == 14'd0))
    `SVD_ASSERT_NEXT(a_frame_end_idle, m_tvalid && m_tready && m_tlast, s_tready && !pend_reg)

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// self-checking testbench for the soft viterbi k5 decoder with depuncturing
`default_nettype none
module tb;
    import svd_pkg::*;

    typedef struct {
        bit [7:0]  data;
        bit [5:0]  num;
        bit        fin;
        bit [31:0] cost;
        bit        err;
    } dec_beat_t;

    typedef struct {
        bit [15:0] sym;
        bit        last;
        bit        typed;   // expected beat given in the row
        bit [7:0]  exp_data;
        bit [31:0] exp_cost;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = CFG_DEPUNCT;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    soft_viterbi_k5_depunctured_decoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // decoder shadow: configuration and frame state
    bit        dp_en;
    bit [63:0] dp_pattern;
    bit [6:0]  dp_period;
    bit [31:0] metric[NUM_STATES];
    bit [15:0] survivors[256];
    bit [15:0] held;
    bit        pending;
    int        ppos, nsteps, nerased;
    bit        overflow;

    dec_beat_t expected_beats[$];
    dec_beat_t frame_beats[$];
    int  mismatches = 0;
    int  beats_seen = 0;
    int  items_sent = 0;
    int  frames_sent = 0;
    bit  idle_on = 1'b1;
    bit  long_hold = 1'b0;

    function automatic bit [31:0] absd(bit [15:0] a, bit [15:0] b);
        return (a > b) ? 32'(a - b) : 32'(b - a);
    endfunction

    task automatic clear_frame();
        for (int k = 0; k < NUM_STATES; k++) metric[k] = BIG_METRIC;
        metric[0] = 0;
        held = 0; pending = 0; ppos = 0; nsteps = 0; nerased = 0; overflow = 0;
    endtask

    task automatic acs_pair(bit [15:0] a, bit [15:0] b);
        bit [31:0] nxt[NUM_STATES];
        bit [15:0] dec;
        bit [15:0] ea, eb;
        bit [31:0] bm0, bm1, m0, m1, m2, m3;
        if (nsteps >= 256) begin
            overflow = 1;
            return;
        end
        dec = 0;
        for (int i = 0; i < NUM_STATES / 2; i++) begin
            ea = EXP_A_MASK[i] ? 16'hFFFF : 16'h0000;
            eb = EXP_B_MASK[i] ? 16'hFFFF : 16'h0000;
            bm0 = absd(ea, a) + absd(eb, b);
            bm1 = 32'(BM_SUM) - bm0;
            m0 = metric[i] + bm0;
            m1 = metric[i + 8] + bm1;
            m2 = metric[i] + bm1;
            m3 = metric[i + 8] + bm0;
            if (m0 >= m1) begin
                dec[2*i] = 1; nxt[2*i] = m1;
            end else nxt[2*i] = m0;
            if (m2 >= m3) begin
                dec[2*i+1] = 1; nxt[2*i+1] = m3;
            end else nxt[2*i+1] = m2;
        end
        survivors[nsteps] = dec;
        nsteps++;
        metric = nxt;
    endtask

    task automatic take_symbol(bit [15:0] s);
        if (pending) begin
            pending = 0;
            acs_pair(held, s);
        end else begin
            held = s;
            pending = 1;
        end
    endtask

    task automatic erase_one();
        take_symbol(ERASURE);
        if (nerased < 1023) nerased++;
    endtask

    function automatic int period_eff();
        if (dp_period == 0) return 1;
        if (dp_period > PATTERN_MAX) return PATTERN_MAX;
        return dp_period;
    endfunction

    // decode one accepted beat, fills frame_beats when the frame closes
    task automatic decode_symbol(bit [15:0] sym, bit last);
        int p, tries, nbits, nbytes, pos, bitpos;
        bit [7:0] st, obytes[33];
        bit [31:0] cost, corr;
        frame_beats.delete();
        if (dp_en) begin
            p = period_eff();
            tries = 0;
            while (tries + 1 < p && dp_pattern[ppos] == 1'b0) begin
                erase_one();
                ppos = (ppos + 1 >= p) ? 0 : ppos + 1;
                tries++;
            end
            take_symbol(sym);
            ppos = (ppos + 1 >= p) ? 0 : ppos + 1;
        end else take_symbol(sym);
        if (!last) return;
        if (pending) erase_one();
        if (overflow) begin
            frame_beats.push_back('{8'h00, 6'd0, 1'b1, ERR_COST, 1'b1});
            clear_frame();
            return;
        end
        foreach (obytes[k]) obytes[k] = 0;
        nbits = nsteps + 4;
        nbytes = (nbits + 7) / 8;
        st = 0; pos = nsteps; bitpos = nbits;
        while (pos > 0) begin
            pos--; bitpos--;
            if (survivors[pos][st >> 4]) begin
                st = (st >> 1) | 8'h80;
                obytes[bitpos / 8][7 - bitpos % 8] = 1'b1;
            end else st = st >> 1;
        end
        cost = metric[0];
        for (int k = 1; k < NUM_STATES; k++) if (metric[k] < cost) cost = metric[k];
        corr = 32'(nerased) * 32'h7FFF;
        cost = (cost > corr) ? cost - corr : 0;
        for (int k = 0; k < nbytes; k++)
            frame_beats.push_back('{obytes[k], 6'(k), k + 1 == nbytes,
                                    (k + 1 == nbytes) ? cost : 32'd0, 1'b0});
        clear_frame();
    endtask

    // offer one beat at the falling edge, hold it until taken
    task automatic send_symbol(bit [15:0] sym, bit last, bit typed = 0,
                               bit [7:0] xd = 0, bit [31:0] xc = 0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tdata = sym;
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        decode_symbol(sym, last);
        if (last && typed) expected_beats.push_back('{xd, 6'd0, 1'b1, xc, 1'b0});
        else foreach (frame_beats[k]) expected_beats.push_back(frame_beats[k]);
        items_sent++;
        if (last) frames_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(int len);
        for (int k = 0; k < len; k++)
            send_symbol(16'($urandom), k == len - 1);
    endtask

    task automatic write_reg(bit [CFG_AW-1:0] idx, bit [63:0] val);
        s_tvalid = 1'b0;
        wait (expected_beats.size() == 0);
        repeat (60) @(negedge aclk);
        cfg_wr_en = 1'b1; cfg_addr = idx; cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_DEPUNCT: dp_en = val[0];
            CFG_PATTERN: dp_pattern = val;
            default:     dp_period = val[6:0];
        endcase
    endtask

    task automatic set_mode(bit en, bit [63:0] pat, bit [6:0] per);
        write_reg(CFG_DEPUNCT, 64'(en));
        write_reg(CFG_PATTERN, pat);
        write_reg(CFG_PERIOD, 64'(per));
    endtask

    // receiver: random ready bursts, plus one long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (2000) @(negedge aclk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        dec_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== {2'b00, want.cost, want.num, want.data} ||
                    m_tlast !== want.fin || m_tuser !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: exp byte %h num %0d last %b cost %h err %b, got byte %h num %0d last %b cost %h err %b",
                                 beats_seen, want.data, want.num, want.fin, want.cost,
                                 want.err, m_tdata[7:0], m_tdata[13:8], m_tlast,
                                 m_tdata[45:14], m_tuser);
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    stim_row_t directed[] = '{
        // lone symbol paired with an erasure, cost fully corrected
        '{16'h0000, 1'b1, 1'b1, 8'h00, 32'd0},
        '{16'h0000, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h0000, 1'b1, 1'b1, 8'h00, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hFFFF, 1'b1, 1'b1, 8'h00, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h0000, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h7FFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h8000, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h0001, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hFFFE, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h0000, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h5555, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hAAAA, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h0000, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
        '{16'h1234, 1'b1, 1'b0, 8'h00, 32'd0}
    };

    initial begin
        dp_en = 0; dp_pattern = '1; dp_period = 1;
        clear_frame();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed[r])
            send_symbol(directed[r].sym, directed[r].last, directed[r].typed,
                        directed[r].exp_data, directed[r].exp_cost);

        // every symbol received, explicit setting
        set_mode(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
        repeat (3) send_frame($urandom_range(1, 12));
        // empty pattern at full period: long erasure runs, last frame overflows
        set_mode(1'b1, 64'h0, 7'd64);
        repeat (3) send_frame($urandom_range(1, 3));
        send_frame(9);
        // zero period acts as one
        set_mode(1'b1, 64'h0, 7'd0);
        repeat (2) send_frame($urandom_range(1, 8));
        // period above the pattern length is clamped
        set_mode(1'b1, {$urandom, $urandom}, 7'd127);
        repeat (2) send_frame($urandom_range(1, 12));
        // rate 3/4 style pattern, with a long receiver hold while frames keep coming
        set_mode(1'b1, 64'h3, 7'd3);
        long_hold = 1'b1;
        repeat (2) send_frame($urandom_range(12, 20));
        set_mode(1'b1, {$urandom, $urandom}, 7'($urandom_range(1, 64)));
        repeat (3) send_frame($urandom_range(1, 12));
        // plain mode again
        set_mode(1'b0, {$urandom, $urandom}, 7'($urandom_range(1, 64)));
        repeat (2) send_frame($urandom_range(1, 12));
        idle_on = 1'b0;
        repeat (2) send_frame($urandom_range(1, 12));
        s_tvalid = 1'b0;

        wait (expected_beats.size() == 0);
        repeat (200) @(posedge aclk);
        $display("covered %0d symbol beats in %0d frames, %0d result beats checked",
                 items_sent, frames_sent, beats_seen);
        $display("modes: plain, full/empty/mixed patterns, clamped periods, overflow");
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
